// ===== design/asq_pkg.sv =====
// ----------------------------------------------------------------------------
// asq_pkg
// Shared constants and types for the ADC scan sequencer with channel filters.
// ----------------------------------------------------------------------------
package asq_pkg;

    localparam int NUM_CHANNELS = 3;
    localparam int SAMPLE_BITS  = 12;
    localparam int CH_BITS      = 2;
    localparam int SHIFT_BITS   = 4;
    localparam int SHIFT_MIN    = 1;
    localparam int SHIFT_MAX    = 8;
    localparam int SHIFT_RESET  = 4;
    localparam int ACC_BITS     = SAMPLE_BITS + SHIFT_MAX;
    localparam int LAST_PHASE   = 2 * NUM_CHANNELS;
    localparam int PHASE_BITS   = $clog2(LAST_PHASE + 1);

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef logic [SAMPLE_BITS-1:0] t_sample;
    typedef logic [ACC_BITS-1:0]    t_acc;
    typedef logic [SHIFT_BITS-1:0]  t_shift;
    typedef logic [CH_BITS-1:0]     t_chan;
    typedef logic [PHASE_BITS-1:0]  t_phase;

    typedef t_sample t_sample_arr [NUM_CHANNELS];

    typedef struct packed {
        logic    cmd;
        logic    conv_ready;
        t_sample conv_result;
        t_chan   read_channel;
    } t_item;

    // sequencer outputs for one tick
    typedef struct packed {
        t_chan mux_select;
        logic  start_conv;
        logic  flush_conv;
        logic  captured;
    } t_seq_res;

    typedef struct packed {
        t_seq_res seq;
        t_sample  filtered_value;
    } t_result;

endpackage

// ===== design/asq_ifs.sv =====
// ----------------------------------------------------------------------------
// asq_ifs
// Valid/ready channel interfaces: item input, result output, config write.
// ----------------------------------------------------------------------------
interface asq_in_if import asq_pkg::*; ();
    logic    valid;
    logic    ready;
    logic    cmd;
    logic    conv_ready;
    t_sample conv_result;
    t_chan   read_channel;

    modport source (output valid, cmd, conv_ready, conv_result, read_channel,
                    input ready);
    modport sink   (input valid, cmd, conv_ready, conv_result, read_channel,
                    output ready);
endinterface

interface asq_out_if import asq_pkg::*; ();
    logic    valid;
    logic    ready;
    t_chan   mux_select;
    logic    start_conv;
    logic    flush_conv;
    logic    captured;
    t_sample filtered_value;

    modport source (output valid, mux_select, start_conv, flush_conv, captured,
                    filtered_value, input ready);
    modport sink   (input valid, mux_select, start_conv, flush_conv, captured,
                    filtered_value, output ready);
endinterface

interface asq_cfg_if import asq_pkg::*; ();
    logic   valid;
    logic   ready;
    t_shift data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ===== design/adc_scan_sequencer_with_ema_core.sv =====
// ----------------------------------------------------------------------------
// adc_scan_sequencer_with_ema_core
// Round-robin three-channel ADC scan sequencer with a leaky-integrator
// filter per channel.
// ----------------------------------------------------------------------------
// One transaction is accepted every clock while no result is stalled, and
// one result leaves per item, in order: the item is held in an input
// register, the sequencer or filter works on it combinationally, and the answer waits in
// the result register until taken. Both registers advance together: while a
// result is stalled the input register still takes one transaction if it is
// empty, then the input holds off until the result is taken. A tick advances
// the scan phase unless an odd phase waits for conv_ready; a read of a valid
// channel updates its accumulator. Write filter_shift only while no item is in flight.
module adc_scan_sequencer_with_ema_core import asq_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    asq_in_if.sink    s_in,
    asq_out_if.source m_out,
    asq_cfg_if.sink   s_cfg
);

    logic        r_s1_valid;
    t_item       r_s1_item;
    logic        r_out_valid;
    t_result     r_out;
    t_shift      r_shift;
    logic        out_free;
    logic        step;
    t_seq_res    seq_res;
    t_sample_arr samples;
    t_sample     fval;

    assign out_free   = !r_out_valid || m_out.ready;
    assign step       = r_s1_valid && out_free;
    assign s_in.ready = !r_s1_valid || step;
    assign s_cfg.ready = 1'b1;

    asq_sequencer u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .i_item    (r_s1_item),
        .o_res     (seq_res),
        .o_samples (samples)
    );

    asq_filter u_filt (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .i_item    (r_s1_item),
        .i_shift   (r_shift),
        .i_samples (samples),
        .o_value   (fval)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_shift     <= SHIFT_BITS'(SHIFT_RESET);
        end else begin
            if (s_in.ready) begin
                r_s1_valid <= s_in.valid;
            end
            if (out_free) begin
                r_out_valid <= r_s1_valid;
            end
            if (s_cfg.valid) begin
                r_shift <= s_cfg.data;
            end
        end
    end

    // payload: load on transaction, hold otherwise
    always_ff @(posedge i_clk) begin
        if (s_in.valid && s_in.ready) begin
            r_s1_item.cmd          <= s_in.cmd;
            r_s1_item.conv_ready   <= s_in.conv_ready;
            r_s1_item.conv_result  <= s_in.conv_result;
            r_s1_item.read_channel <= s_in.read_channel;
        end
        if (step) begin
            r_out.seq            <= seq_res;
            r_out.filtered_value <= fval;
        end
    end

    assign m_out.valid          = r_out_valid;
    assign m_out.mux_select     = r_out.seq.mux_select;
    assign m_out.start_conv     = r_out.seq.start_conv;
    assign m_out.flush_conv     = r_out.seq.flush_conv;
    assign m_out.captured       = r_out.seq.captured;
    assign m_out.filtered_value = r_out.filtered_value;

    a_pulse_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.seq.start_conv && r_out.seq.flush_conv))
        else $error("start and flush pulses on the same result");

    a_cap_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.seq.captured == r_out.seq.flush_conv))
        else $error("captured and flush disagree");

    a_tick_no_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.seq.start_conv || r_out.seq.flush_conv))
            |-> (r_out.filtered_value == '0))
        else $error("filtered value on a tick result");

    a_mux_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.seq.start_conv) |-> (r_out.seq.mux_select == '0))
        else $error("mux select without a conversion start");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !r_out_valid) |=> r_out_valid)
        else $error("input register did not drain into free result register");

endmodule

// ===== design/asq_sequencer.sv =====
// ----------------------------------------------------------------------------
// asq_sequencer
// Scan phase counter and per-channel sample registers. Even phases start a
// conversion, odd phases wait for ready and capture, the last phase wraps.
// ----------------------------------------------------------------------------
module asq_sequencer import asq_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  t_item       i_item,
    output t_seq_res    o_res,
    output t_sample_arr o_samples
);

    t_phase      r_phase;
    t_phase      n_phase;
    t_sample_arr r_sample;
    t_chan       ch;
    logic        cap;

    assign ch = CH_BITS'(r_phase >> 1);

    always_comb begin
        n_phase = r_phase;
        o_res   = '0;
        cap     = 1'b0;
        if (i_item.cmd == CMD_TICK) begin
            if (r_phase >= PHASE_BITS'(LAST_PHASE)) begin
                n_phase = '0;
            end else if (!r_phase[0]) begin
                o_res.mux_select = ch;
                o_res.start_conv = 1'b1;
                n_phase          = r_phase + 1'b1;
            end else if (i_item.conv_ready) begin
                o_res.flush_conv = 1'b1;
                o_res.captured   = 1'b1;
                cap              = 1'b1;
                n_phase          = r_phase + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= '0;
            r_sample <= '{default: '0};
        end else if (i_step) begin
            r_phase <= n_phase;
            if (cap) begin
                r_sample[ch] <= i_item.conv_result;
            end
        end
    end

    assign o_samples = r_sample;

endmodule

// ===== design/asq_filter.sv =====
// ----------------------------------------------------------------------------
// asq_filter
// Per-channel leaky integrator: acc = acc - (acc >> k) + sample, output
// acc >> k saturated to the sample range.
// ----------------------------------------------------------------------------
module asq_filter import asq_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  t_item       i_item,
    input  t_shift      i_shift,
    input  t_sample_arr i_samples,
    output t_sample     o_value
);

    t_acc    r_acc [NUM_CHANNELS];
    t_shift  k;
    logic    hit;
    t_acc    acc;
    t_sample smp;
    t_acc    n_acc;
    t_acc    q;

    always_comb begin
        if (i_shift < SHIFT_BITS'(SHIFT_MIN)) begin
            k = SHIFT_BITS'(SHIFT_MIN);
        end else if (i_shift > SHIFT_BITS'(SHIFT_MAX)) begin
            k = SHIFT_BITS'(SHIFT_MAX);
        end else begin
            k = i_shift;
        end
    end

    always_comb begin
        hit   = (i_item.cmd == CMD_READ) &&
                (i_item.read_channel < CH_BITS'(NUM_CHANNELS));
        acc   = '0;
        smp   = '0;
        if (hit) begin
            acc = r_acc[i_item.read_channel];
            smp = i_samples[i_item.read_channel];
        end
        n_acc = acc - (acc >> k) + {{SHIFT_MAX{1'b0}}, smp};
        q     = n_acc >> k;
        if (!hit) begin
            o_value = '0;
        end else if (|q[ACC_BITS-1:SAMPLE_BITS]) begin
            o_value = '1;
        end else begin
            o_value = q[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '{default: '0};
        end else if (i_step && hit) begin
            r_acc[i_item.read_channel] <= n_acc;
        end
    end

endmodule
